/* rtl/swsk_pkg.sv */
// Shared types and constants for the sliding-window stochastic %K unit.
// Used by the controller, datapath, top level and checker; depends on nothing.
package swsk_pkg;

	localparam int WINDOW_MAX_DEF = 64;
	localparam int PRICE_BITS_DEF = 32;
	localparam int IN_W           = 32;
	localparam int CFG_W          = 7;
	localparam int K_W            = 15;
	localparam int K_SCALE        = 25600;
	localparam int WL_RESET       = 14;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SCAN,
		ST_DRAIN,
		ST_PREP,
		ST_MUL,
		ST_DIVIDE,
		ST_DONE
	} state_t;

	typedef struct packed {
		logic accept;
		logic cfg_wr;
		logic issue;
		logic prep;
		logic mul;
		logic step;
		logic load;
	} cmd_t;

	typedef struct packed {
		logic warm;
		logic one;
		logic scan_last;
		logic flat;
		logic div_last;
		logic out_free;
	} sts_t;

endpackage

/* rtl/swsk_ram.sv */
// Generic single-write, single-read RAM with registered read data.
// Holds the price window; depends on nothing.
module swsk_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		rd_data <= mem[rd_addr];
	end

endmodule

/* rtl/swsk_ctrl.sv */
// Controller state machine for the stochastic %K unit.
// Depends on swsk_pkg for the state, command and status types.
module swsk_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	input  logic          cfg_valid,
	input  swsk_pkg::sts_t sts,
	output logic          in_ready,
	output logic          cfg_ready,
	output swsk_pkg::cmd_t cmd
);

	swsk_pkg::state_t state_q;
	swsk_pkg::state_t state_nx;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= swsk_pkg::ST_IDLE;
		end else begin
			state_q <= state_nx;
		end
	end

	always_comb begin
		state_nx = state_q;
		unique case (state_q)
			swsk_pkg::ST_IDLE: begin
				if (in_valid) begin
					if (sts.warm) begin
						state_nx = swsk_pkg::ST_DONE;
					end else if (sts.one) begin
						state_nx = swsk_pkg::ST_PREP;
					end else begin
						state_nx = swsk_pkg::ST_SCAN;
					end
				end
			end
			swsk_pkg::ST_SCAN: begin
				if (sts.scan_last) begin
					state_nx = swsk_pkg::ST_DRAIN;
				end
			end
			swsk_pkg::ST_DRAIN:  state_nx = swsk_pkg::ST_PREP;
			swsk_pkg::ST_PREP: begin
				state_nx = sts.flat ? swsk_pkg::ST_DONE : swsk_pkg::ST_MUL;
			end
			swsk_pkg::ST_MUL:    state_nx = swsk_pkg::ST_DIVIDE;
			swsk_pkg::ST_DIVIDE: begin
				if (sts.div_last) begin
					state_nx = swsk_pkg::ST_DONE;
				end
			end
			swsk_pkg::ST_DONE: begin
				if (sts.out_free) begin
					state_nx = swsk_pkg::ST_IDLE;
				end
			end
			default: state_nx = swsk_pkg::ST_IDLE;
		endcase
	end

	always_comb begin
		in_ready   = (state_q == swsk_pkg::ST_IDLE);
		cfg_ready  = (state_q == swsk_pkg::ST_IDLE);
		cmd.accept = in_ready && in_valid;
		cmd.cfg_wr = cfg_ready && cfg_valid;
		cmd.issue  = (state_q == swsk_pkg::ST_SCAN);
		cmd.prep   = (state_q == swsk_pkg::ST_PREP);
		cmd.mul    = (state_q == swsk_pkg::ST_MUL);
		cmd.step   = (state_q == swsk_pkg::ST_DIVIDE);
		cmd.load   = (state_q == swsk_pkg::ST_DONE) && sts.out_free;
	end

endmodule

/* rtl/swsk_datapath.sv */
// Datapath: window store, min/max scan, scaling multiply, restoring divide
// and output register. Depends on swsk_pkg and swsk_ram.
module swsk_datapath #(
	parameter int WINDOW_MAX = swsk_pkg::WINDOW_MAX_DEF,
	parameter int PRICE_BITS = swsk_pkg::PRICE_BITS_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  swsk_pkg::cmd_t              cmd,
	output swsk_pkg::sts_t              sts,
	input  logic [swsk_pkg::IN_W-1:0]   close_price,
	input  logic [swsk_pkg::CFG_W-1:0]  window_length,
	input  logic                        out_ready,
	output logic                        out_valid,
	output logic [swsk_pkg::K_W-1:0]    percent_k,
	output logic                        warming_up,
	output logic                        flat_window
);

	localparam int AW    = $clog2(WINDOW_MAX);
	localparam int CW    = swsk_pkg::CFG_W;
	localparam int KW    = swsk_pkg::K_W;
	localparam int NW    = PRICE_BITS + KW;
	localparam int DCW   = $clog2(KW + 1);
	localparam logic [CW-1:0] N_MAX = (WINDOW_MAX > 127) ? CW'(127) : CW'(WINDOW_MAX);

	logic [CW-1:0]         wl_q;
	logic [CW-1:0]         seen_q;
	logic [AW-1:0]         slot_q;
	logic [AW-1:0]         rd_addr_q;
	logic [CW-1:0]         cnt_q;
	logic                  rd_valid_s1;
	logic [PRICE_BITS-1:0] rd_data;
	logic [PRICE_BITS-1:0] close_q;
	logic [PRICE_BITS-1:0] lo_q;
	logic [PRICE_BITS-1:0] hi_q;
	logic [PRICE_BITS-1:0] diff_q;
	logic [PRICE_BITS-1:0] den_q;
	logic [PRICE_BITS-1:0] rem_q;
	logic [KW-1:0]         low_q;
	logic [KW-1:0]         quo_q;
	logic [DCW-1:0]        div_cnt_q;
	logic                  warm_q;
	logic                  flat_q;
	logic                  out_valid_q;
	logic [KW-1:0]         k_q;
	logic                  warming_q;
	logic                  flatw_q;

	logic [PRICE_BITS-1:0] close_ext;
	logic [CW-1:0]         n;
	logic [CW-1:0]         seen_nx;
	logic [NW-1:0]         prod;
	logic [PRICE_BITS:0]   trial;
	logic                  qbit;

	assign close_ext = PRICE_BITS'(close_price);

	always_comb begin
		if (wl_q == '0) begin
			n = CW'(1);
		end else if (32'(wl_q) > 32'(WINDOW_MAX)) begin
			n = N_MAX;
		end else begin
			n = wl_q;
		end
		seen_nx = (seen_q < n) ? seen_q + 1'b1 : n;
	end

	assign prod  = NW'(diff_q) * NW'(swsk_pkg::K_SCALE);
	assign trial = {rem_q, low_q[KW-1]};
	assign qbit  = (trial >= {1'b0, den_q});

	assign sts.warm      = (seen_nx < n);
	assign sts.one       = (n == CW'(1));
	assign sts.scan_last = (cnt_q == CW'(1));
	assign sts.flat      = (hi_q == lo_q);
	assign sts.div_last  = (div_cnt_q == DCW'(1));
	assign sts.out_free  = !out_valid_q || out_ready;

	swsk_ram #(
		.WIDTH(PRICE_BITS),
		.DEPTH(WINDOW_MAX)
	) u_window (
		.clk    (clk),
		.wr_en  (cmd.accept),
		.wr_addr(slot_q),
		.wr_data(close_ext),
		.rd_addr(rd_addr_q),
		.rd_data(rd_data)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wl_q        <= CW'(swsk_pkg::WL_RESET);
			seen_q      <= '0;
			slot_q      <= '0;
			rd_valid_s1 <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			rd_valid_s1 <= cmd.issue;
			if (cmd.cfg_wr) begin
				wl_q   <= window_length;
				seen_q <= '0;
			end else if (cmd.accept) begin
				seen_q <= seen_nx;
			end
			if (cmd.accept) begin
				slot_q <= (slot_q == AW'(WINDOW_MAX - 1)) ? '0 : slot_q + 1'b1;
			end
			if (cmd.load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			close_q   <= close_ext;
			lo_q      <= close_ext;
			hi_q      <= close_ext;
			warm_q    <= sts.warm;
			cnt_q     <= n - 1'b1;
			rd_addr_q <= (slot_q == '0) ? AW'(WINDOW_MAX - 1) : slot_q - 1'b1;
		end
		if (cmd.issue) begin
			cnt_q     <= cnt_q - 1'b1;
			rd_addr_q <= (rd_addr_q == '0) ? AW'(WINDOW_MAX - 1) : rd_addr_q - 1'b1;
		end
		if (rd_valid_s1) begin
			if (rd_data < lo_q) begin
				lo_q <= rd_data;
			end
			if (rd_data > hi_q) begin
				hi_q <= rd_data;
			end
		end
		if (cmd.prep) begin
			diff_q <= close_q - lo_q;
			den_q  <= hi_q - lo_q;
			flat_q <= (hi_q == lo_q);
		end
		if (cmd.mul) begin
			rem_q     <= prod[NW-1:KW];
			low_q     <= prod[KW-1:0];
			div_cnt_q <= DCW'(KW);
		end
		if (cmd.step) begin
			rem_q     <= qbit ? PRICE_BITS'(trial - {1'b0, den_q}) : trial[PRICE_BITS-1:0];
			low_q     <= {low_q[KW-2:0], 1'b0};
			quo_q     <= {quo_q[KW-2:0], qbit};
			div_cnt_q <= div_cnt_q - 1'b1;
		end
		if (cmd.load) begin
			k_q       <= (warm_q || flat_q) ? '0 : quo_q;
			warming_q <= warm_q;
			flatw_q   <= !warm_q && flat_q;
		end
	end

	assign out_valid   = out_valid_q;
	assign percent_k   = k_q;
	assign warming_up  = warming_q;
	assign flat_window = flatw_q;

endmodule

/* rtl/sliding_window_stochastic_k_unit.sv */
// Top level of the sliding-window stochastic %K unit.
// Depends on swsk_pkg, swsk_ctrl and swsk_datapath.
//
// channel  direction  handshake              payload
// in       input      in_valid / in_ready    close_price
// out      output     out_valid / out_ready  percent_k, warming_up, flat_window
// cfg      input      cfg_valid / cfg_ready  window_length
//
// One item at a time, for window length n. A warm-up item goes straight to the
// result and a window of length one through the prep step; otherwise n - 1 window
// reads through the single RAM read port and a drain, then a flat window goes to
// the result and any other through a multiply and a 15-step restoring divide.
// No clearing pass after reset; in_ready and cfg_ready are high only when idle.
// A new item is accepted while the previous result still waits on out_ready.
module sliding_window_stochastic_k_unit #(
	parameter int WINDOW_MAX = swsk_pkg::WINDOW_MAX_DEF,
	parameter int PRICE_BITS = swsk_pkg::PRICE_BITS_DEF
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       in_valid,
	output logic                       in_ready,
	input  logic [swsk_pkg::IN_W-1:0]  close_price,
	output logic                       out_valid,
	input  logic                       out_ready,
	output logic [swsk_pkg::K_W-1:0]   percent_k,
	output logic                       warming_up,
	output logic                       flat_window,
	input  logic                       cfg_valid,
	output logic                       cfg_ready,
	input  logic [swsk_pkg::CFG_W-1:0] window_length
);

	swsk_pkg::cmd_t cmd;
	swsk_pkg::sts_t sts;

	swsk_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.cfg_valid(cfg_valid),
		.sts      (sts),
		.in_ready (in_ready),
		.cfg_ready(cfg_ready),
		.cmd      (cmd)
	);

	swsk_datapath #(
		.WINDOW_MAX(WINDOW_MAX),
		.PRICE_BITS(PRICE_BITS)
	) u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.sts          (sts),
		.close_price  (close_price),
		.window_length(window_length),
		.out_ready    (out_ready),
		.out_valid    (out_valid),
		.percent_k    (percent_k),
		.warming_up   (warming_up),
		.flat_window  (flat_window)
	);

endmodule

/* rtl/swsk_checker.sv */
// Port-level checks for the stochastic %K unit, bound to the top level.
// Depends on swsk_pkg for field widths.
module swsk_checker (
	input logic                       clk,
	input logic                       arst_n,
	input logic                       in_valid,
	input logic                       in_ready,
	input logic                       out_valid,
	input logic                       out_ready,
	input logic [swsk_pkg::K_W-1:0]   percent_k,
	input logic                       warming_up,
	input logic                       flat_window
);

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(percent_k)
		&& $stable(warming_up) && $stable(flat_window))
		else $error("result changed while stalled");

	a_flags_excl: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> !(warming_up && flat_window))
		else $error("warm-up and flat flags both set");

	a_flag_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (warming_up || flat_window) |-> percent_k == '0)
		else $error("flagged result carries nonzero %%K");

	a_k_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> percent_k <= swsk_pkg::K_W'(swsk_pkg::K_SCALE))
		else $error("%%K above full scale");

	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("item accepted while previous item in progress");

endmodule

bind sliding_window_stochastic_k_unit swsk_checker u_chk (
	.clk        (clk),
	.arst_n     (arst_n),
	.in_valid   (in_valid),
	.in_ready   (in_ready),
	.out_valid  (out_valid),
	.out_ready  (out_ready),
	.percent_k  (percent_k),
	.warming_up (warming_up),
	.flat_window(flat_window)
);
